// ===== rtl/swt_pkg.sv =====
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and constants for the sleep/wakeup timer table.
// ----------------------------------------------------------------------------
package swt_pkg;

    // result kinds carried on the master-side tuser
    typedef enum logic [1:0] {
        EV_WAKE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_FULL   = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WR,
        ST_FULL,
        ST_SCAN
    } t_state;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int MS_PER_S    = 1000;
    // floor(x / 1000) == (x * DIV1000_MUL) >> DIV1000_SH for any 32-bit x
    localparam logic [31:0] DIV1000_MUL = 32'h10624DD3;
    localparam int DIV1000_SH  = 38;
    localparam int CONV_STEPS  = 3;     // ms-to-tick conversion steps
    localparam int TID_W       = 8;
    localparam int MS_W        = 32;
    localparam int TICK_W      = 64;

    localparam int S_TDATA_W   = 40;    // thread_id, sleep_ms
    localparam int M_TDATA_W   = 72;    // woken_thread, now

endpackage

// ===== rtl/sleep_wakeup_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// sleep_wakeup_timer_table_core
// Tick counter with a table of sleeping threads; wakes due threads on ticks.
// ----------------------------------------------------------------------------
// Sleep request: accept, ms-to-tick conversion by reciprocal multiplication
//   in ST_DIV, then the write in ST_WR; a full table is answered from ST_FULL.
// Tick: accept, then the one-slot-per-cycle table scan through the RAM read
//   port, held while the output is stalled.
// One item in flight at a time. Reset clears the tick counter and the slot
//   valid flops at once; no clearing pass, table RAM contents are don't-care.
module sleep_wakeup_timer_table_core
    import swt_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int TICK_HZ = 1000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] thread_id, [39:8] sleep_ms
    input  logic                 s_tuser,   // [0] req_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] woken_thread, [71:8] now
    output logic [1:0]           m_tuser,   // [1:0] event_res
    output logic                 m_tlast
);

    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW     = $clog2(SLOTS + 1);
    localparam int TICK_Q = TICK_HZ / MS_PER_S;    // whole ticks per ms
    localparam int TICK_R = TICK_HZ % MS_PER_S;    // leftover ticks per 1000 ms
    localparam int QW     = MS_W - 9;              // ms / 1000 fits 23 bits
    localparam int LW     = 10;                    // ms % 1000
    localparam int CW     = $clog2(CONV_STEPS + 1);
    localparam int RW     = TID_W + TICK_W;

    t_state               r_state, n_state;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [SLOTS-1:0]     r_valid, n_valid;
    logic [AW-1:0]        r_slot, n_slot;
    logic [TID_W-1:0]     r_tid, n_tid;
    logic [MS_W-1:0]      r_ms, n_ms;
    logic [QW-1:0]        r_qh, n_qh;
    logic [LW-1:0]        r_lo, n_lo;
    logic [TICK_W-1:0]    r_ticks, n_ticks;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]        r_cmp_idx, n_cmp_idx;
    logic [RES_W-1:0]     r_nres, n_nres;
    logic                 r_pend_vld, n_pend_vld;
    logic [TID_W-1:0]     r_pend_tid, n_pend_tid;

    logic                 r_out_vld, n_out_vld;
    t_event               r_out_ev, n_out_ev;
    logic [TID_W-1:0]     r_out_tid, n_out_tid;
    logic [TICK_W-1:0]    r_out_now, n_out_now;
    logic                 r_out_last, n_out_last;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [RW-1:0]        ram_wdata, ram_rdata;
    logic [TID_W-1:0]     ram_tid;
    logic [TICK_W-1:0]    ram_wake;

    logic                 in_acc;
    logic [TID_W-1:0]     in_tid;
    logic [MS_W-1:0]      in_ms;
    logic                 out_free;
    logic                 free_found;
    logic [AW-1:0]        free_idx;
    logic                 cmp_due;
    logic                 stall;
    logic [2*MS_W-1:0]    ms_prod;
    logic [MS_W-1:0]      lo_x_r;
    logic [2*MS_W-1:0]    frac_prod;

    assign in_tid   = s_tdata[TID_W-1:0];
    assign in_ms    = s_tdata[TID_W+MS_W-1:TID_W];
    assign s_tready = (r_state == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !r_out_vld || m_tready;

    assign ram_tid  = ram_rdata[RW-1:TICK_W];
    assign ram_wake = ram_rdata[TICK_W-1:0];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    // ticks = ms*Q + (ms/1000)*R + (ms%1000)*R/1000, with TICK_HZ = 1000*Q + R
    assign ms_prod   = (2*MS_W)'(r_ms) * (2*MS_W)'(DIV1000_MUL);
    assign lo_x_r    = MS_W'(r_lo) * MS_W'(TICK_R);
    assign frac_prod = (2*MS_W)'(lo_x_r) * (2*MS_W)'(DIV1000_MUL);

    assign cmp_due = r_cmp_vld && r_valid[r_cmp_idx] && (r_tick >= ram_wake)
                     && (r_nres < RES_W'(MAX_RESULTS));
    // a second hit while the pending word cannot move out holds the scan
    assign stall   = cmp_due && r_pend_vld && !out_free;

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_valid    = r_valid;
        n_slot     = r_slot;
        n_tid      = r_tid;
        n_ms       = r_ms;
        n_qh       = r_qh;
        n_lo       = r_lo;
        n_ticks    = r_ticks;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_nres     = r_nres;
        n_pend_vld = r_pend_vld;
        n_pend_tid = r_pend_tid;
        n_out_vld  = r_out_vld && !m_tready;
        n_out_ev   = r_out_ev;
        n_out_tid  = r_out_tid;
        n_out_now  = r_out_now;
        n_out_last = r_out_last;
        ram_we     = 1'b0;
        ram_wdata  = {r_tid, r_tick + r_ticks};
        ram_raddr  = stall ? r_cmp_idx : r_idx[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_tid = in_tid;
                    if (s_tuser) begin
                        n_slot  = free_idx;
                        n_ms    = in_ms;
                        n_cnt   = CW'(CONV_STEPS);
                        n_state = free_found ? ST_DIV : ST_FULL;
                    end else begin
                        n_tick     = r_tick + TICK_W'(1);
                        n_idx      = '0;
                        n_cmp_vld  = 1'b0;
                        n_nres     = '0;
                        n_pend_vld = 1'b0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(CONV_STEPS)) begin
                    n_qh = ms_prod[DIV1000_SH +: QW];
                end else if (r_cnt == CW'(CONV_STEPS - 1)) begin
                    n_lo    = LW'(r_ms - MS_W'(r_qh) * MS_W'(MS_PER_S));
                    n_ticks = TICK_W'(r_ms) * TICK_W'(TICK_Q)
                              + TICK_W'(r_qh) * TICK_W'(TICK_R);
                end else begin
                    n_ticks = r_ticks + TICK_W'(frac_prod[DIV1000_SH +: LW]);
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                if (out_free) begin
                    ram_we          = 1'b1;
                    n_valid[r_slot] = 1'b1;
                    n_out_vld       = 1'b1;
                    n_out_ev        = EV_ACCEPT;
                    n_out_tid       = r_tid;
                    n_out_now       = r_tick;
                    n_out_last      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_FULL: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_ev   = EV_FULL;
                    n_out_tid  = r_tid;
                    n_out_now  = r_tick;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (cmp_due) begin
                        n_valid[r_cmp_idx] = 1'b0;
                        n_nres             = r_nres + RES_W'(1);
                        n_pend_vld         = 1'b1;
                        n_pend_tid         = ram_tid;
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_ev   = EV_WAKE;
                            n_out_tid  = r_pend_tid;
                            n_out_now  = r_tick;
                            n_out_last = 1'b0;
                        end
                    end
                    if (r_idx < IW'(SLOTS)) begin
                        n_cmp_vld = 1'b1;
                        n_cmp_idx = r_idx[AW-1:0];
                        n_idx     = r_idx + IW'(1);
                    end else begin
                        n_cmp_vld = 1'b0;
                    end
                    // scan finished: the held word is the last one
                    if (r_idx == IW'(SLOTS) && !r_cmp_vld) begin
                        if (!r_pend_vld) begin
                            n_state = ST_IDLE;
                        end else if (out_free) begin
                            n_out_vld  = 1'b1;
                            n_out_ev   = EV_WAKE;
                            n_out_tid  = r_pend_tid;
                            n_out_now  = r_tick;
                            n_out_last = 1'b1;
                            n_pend_vld = 1'b0;
                            n_state    = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tick     <= '0;
            r_valid    <= '0;
            r_cmp_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_nres     <= '0;
            r_idx      <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_valid    <= n_valid;
            r_cmp_vld  <= n_cmp_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_nres     <= n_nres;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_tid      <= n_tid;
        r_ms       <= n_ms;
        r_qh       <= n_qh;
        r_lo       <= n_lo;
        r_ticks    <= n_ticks;
        r_cmp_idx  <= n_cmp_idx;
        r_pend_tid <= n_pend_tid;
        r_out_ev   <= n_out_ev;
        r_out_tid  <= n_out_tid;
        r_out_now  <= n_out_now;
        r_out_last <= n_out_last;
    end

    swt_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {r_out_now, r_out_tid};
    assign m_tuser  = r_out_ev;
    assign m_tlast  = r_out_last;

    // a scan only ever frees slots
    a_scan_no_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> ($countones(r_valid) <= $past($countones(r_valid))))
        else $error("slot allocated during tick scan");

    // a sleep write claims exactly one new slot
    a_alloc_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR && out_free)
        |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("sleep write did not claim one free slot");

    // sleep answers are single words
    a_sleep_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != EV_WAKE) |-> m_tlast)
        else $error("sleep answer without last marker");

    a_res_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_W'(MAX_RESULTS))
        else $error("wake count past limit");

endmodule

// ===== rtl/swt_ram.sv =====
// ----------------------------------------------------------------------------
// swt_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
